>>> rtl/core/srim_pkg.sv
// ----------------------------------------------------------------------------
// srim_pkg
// Shared widths, register codes, pipeline word types and the remainder step
// used by the segmented ring index map.
// ----------------------------------------------------------------------------
package srim_pkg;

   // field widths
   localparam int POS_W     = 16;             // logical_pos, signed
   localparam int MAG_W     = POS_W - 1;      // magnitude of a non-negative position
   localparam int LEN_W     = 11;             // led count, segment start and length
   localparam int IDX_W     = 10;             // physical index
   localparam int SEG_W     = 2 * LEN_W;      // packed segment register
   localparam int CNT_W     = 3;              // segment_count
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = SEG_W;

   // ring total: up to four segments of LEN_W bits each
   localparam int SEG_LIMIT = 4;
   localparam int TOT_W     = LEN_W + $clog2(SEG_LIMIT);

   // defaults for the top level parameters
   localparam int MAX_LEDS_DEF     = 1024;
   localparam int MAX_SEGMENTS_DEF = 4;

   // remainder pipeline: quotient bits resolved per stage
   localparam int STEPS_PER_STAGE = 3;
   localparam int NUM_DIV_STAGES  = (MAG_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LED_COUNT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RING_START    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RING_REVERSE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SEGMENT_COUNT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SEGMENT_0     = 3'd4;

   // settings derived from the registers, shared by the datapath
   typedef struct packed {
      logic [TOT_W-1:0] total;     // sum of clamped segment lengths
      logic [LEN_W-1:0] off_mag;   // magnitude of the rotation offset
      logic             off_neg;   // rotation offset is negative
      logic             reverse;
   } cfg_type;

   // word carried through the remainder stages
   typedef struct packed {
      logic             neg;       // position was negative
      logic [MAG_W-1:0] rem;       // position remainder lane
      logic [MAG_W-1:0] orem;      // offset remainder lane
   } div_item_type;

   // one restoring step: subtract divisor << k when it fits
   function automatic logic [MAG_W-1:0] rem_step(input logic [MAG_W-1:0] r,
                                                 input logic [TOT_W-1:0] d,
                                                 input int k);
      logic [MAG_W+TOT_W-1:0] dk;
      logic [MAG_W+TOT_W-1:0] rw;
      dk = (MAG_W+TOT_W)'(d) << k;
      rw = (MAG_W+TOT_W)'(r);
      if (rw >= dk) begin
         rw = rw - dk;
      end
      return rw[MAG_W-1:0];
   endfunction

endpackage

>>> rtl/core/srim_cfg.sv
// ----------------------------------------------------------------------------
// srim_cfg
// Register file and derived ring settings: clamped segments, ring total,
// segment boundaries and rotation offset magnitude.
// ----------------------------------------------------------------------------
module srim_cfg #(
   parameter int MAX_LEDS     = srim_pkg::MAX_LEDS_DEF,
   parameter int MAX_SEGMENTS = srim_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [srim_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [srim_pkg::CSR_DAT_W-1:0]         csr_wdata,
   output srim_pkg::cfg_type                      cfg,
   output logic [MAX_SEGMENTS-1:0][srim_pkg::LEN_W-1:0] seg_start,
   output logic [MAX_SEGMENTS-1:0][srim_pkg::TOT_W-1:0] seg_begin,
   output logic [MAX_SEGMENTS-1:0][srim_pkg::TOT_W-1:0] seg_end
);
   import srim_pkg::*;

   logic [LEN_W-1:0] led_count_ff;
   logic [LEN_W-1:0] ring_start_ff;
   logic             ring_reverse_ff;
   logic [CNT_W-1:0] segment_count_ff;
   logic [MAX_SEGMENTS-1:0][SEG_W-1:0] seg_ff;

   logic [MAX_SEGMENTS-1:0][LEN_W-1:0] start_in, start_ff;
   logic [MAX_SEGMENTS-1:0][LEN_W-1:0] len_in, len_ff;
   logic [MAX_SEGMENTS-1:0][TOT_W-1:0] begin_in, begin_ff;
   logic [MAX_SEGMENTS-1:0][TOT_W-1:0] end_in, end_ff;
   cfg_type                            cfg_in, cfg_ff;

   logic [LEN_W-1:0] strip_len;
   logic [CNT_W-1:0] seg_used;

   // scalar registers
   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff     <= '0;
         ring_start_ff    <= '0;
         ring_reverse_ff  <= 1'b0;
         segment_count_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_LED_COUNT:     led_count_ff     <= csr_wdata[LEN_W-1:0];
            REG_RING_START:    ring_start_ff    <= csr_wdata[LEN_W-1:0];
            REG_RING_REVERSE:  ring_reverse_ff  <= csr_wdata[0];
            REG_SEGMENT_COUNT: segment_count_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // segment registers, only those that can be in use
   for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_seg
      always_ff @(posedge clock) begin
         if (reset) begin
            seg_ff[k] <= '0;
         end else if (csr_we && csr_index == CSR_IDX_W'(REG_SEGMENT_0 + k)) begin
            seg_ff[k] <= csr_wdata[SEG_W-1:0];
         end
      end
   end

   // strip length and segment count saturate
   assign strip_len = ({1'b0, led_count_ff} > (LEN_W+1)'(MAX_LEDS)) ?
                      LEN_W'(MAX_LEDS) : led_count_ff;
   assign seg_used  = (segment_count_ff > CNT_W'(MAX_SEGMENTS)) ?
                      CNT_W'(MAX_SEGMENTS) : segment_count_ff;

   // clamp each segment to the strip and sum the total
   always_comb begin
      logic [LEN_W-1:0] s;
      logic [LEN_W-1:0] l;
      logic             act;
      logic [LEN_W:0]   end_pt;
      cfg_in = '0;
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
         if (seg_used == '0) begin
            s   = '0;
            l   = strip_len;
            act = (k == 0);
         end else begin
            s   = seg_ff[k][LEN_W-1:0];
            l   = seg_ff[k][SEG_W-1:LEN_W];
            act = (CNT_W'(k) < seg_used);
         end
         end_pt = {1'b0, s} + {1'b0, l};
         if (!act || s > strip_len) begin
            len_in[k] = '0;
         end else if (end_pt > {1'b0, strip_len}) begin
            len_in[k] = strip_len - s;
         end else begin
            len_in[k] = l;
         end
         start_in[k]  = s;
         cfg_in.total = cfg_in.total + TOT_W'(len_in[k]);
      end
      cfg_in.off_neg = ring_start_ff[LEN_W-1];
      cfg_in.off_mag = ring_start_ff[LEN_W-1] ? (~ring_start_ff + LEN_W'(1)) : ring_start_ff;
      cfg_in.reverse = ring_reverse_ff;
   end

   // segment boundaries from the registered lengths
   always_comb begin
      logic [TOT_W-1:0] acc;
      acc = '0;
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
         begin_in[k] = acc;
         acc         = acc + TOT_W'(len_ff[k]);
         end_in[k]   = acc;
      end
   end

   always_ff @(posedge clock) begin
      cfg_ff   <= cfg_in;
      start_ff <= start_in;
      len_ff   <= len_in;
      begin_ff <= begin_in;
      end_ff   <= end_in;
   end

   assign cfg       = cfg_ff;
   assign seg_start = start_ff;
   assign seg_begin = begin_ff;
   assign seg_end   = end_ff;

endmodule

>>> rtl/core/srim_div_stage.sv
// ----------------------------------------------------------------------------
// srim_div_stage
// One remainder stage: a few restoring steps on the position and offset
// lanes against the ring total, then a register.
// ----------------------------------------------------------------------------
module srim_div_stage #(
   parameter int FIRST_K = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  srim_pkg::div_item_type      in_item,
   input  logic [srim_pkg::TOT_W-1:0]  total,
   output logic                        out_valid,
   output srim_pkg::div_item_type      out_item
);
   import srim_pkg::*;

   logic         valid_ff;
   div_item_type item_in, item_ff;

   always_comb begin
      item_in = in_item;
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
         if (FIRST_K - j >= 0) begin
            item_in.rem  = rem_step(item_in.rem, total, FIRST_K - j);
            item_in.orem = rem_step(item_in.orem, total, FIRST_K - j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

>>> rtl/core/srim_locate.sv
// ----------------------------------------------------------------------------
// srim_locate
// Final two stages: reversal, rotation and wrap into the ring, then the
// segment search and the physical index.
// ----------------------------------------------------------------------------
module srim_locate #(
   parameter int MAX_SEGMENTS = srim_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   input  srim_pkg::div_item_type                        in_item,
   input  srim_pkg::cfg_type                             cfg,
   input  logic [MAX_SEGMENTS-1:0][srim_pkg::LEN_W-1:0]  seg_start,
   input  logic [MAX_SEGMENTS-1:0][srim_pkg::TOT_W-1:0]  seg_begin,
   input  logic [MAX_SEGMENTS-1:0][srim_pkg::TOT_W-1:0]  seg_end,
   output logic                                          out_strobe,
   output logic                                          out_phys_valid,
   output logic [srim_pkg::IDX_W-1:0]                    out_phys_index
);
   import srim_pkg::*;

   logic             f1_valid_ff;
   logic             f1_bad_in, f1_bad_ff;
   logic [TOT_W-1:0] f1_pos_in, f1_pos_ff;

   logic             strobe_ff;
   logic             phys_valid_in, phys_valid_ff;
   logic [IDX_W-1:0] phys_index_in, phys_index_ff;

   // reverse, rotate, wrap
   always_comb begin
      logic [TOT_W-1:0] rem_t;
      logic [TOT_W-1:0] orem_t;
      logic [TOT_W-1:0] fwd;
      logic [TOT_W-1:0] rot;
      logic [TOT_W:0]   sum;
      rem_t  = in_item.rem[TOT_W-1:0];
      orem_t = in_item.orem[TOT_W-1:0];
      fwd    = cfg.reverse ? (cfg.total - TOT_W'(1) - rem_t) : rem_t;
      rot    = (cfg.off_neg && orem_t != '0) ? (cfg.total - orem_t) : orem_t;
      sum    = {1'b0, fwd} + {1'b0, rot};
      if (sum >= {1'b0, cfg.total}) begin
         sum = sum - {1'b0, cfg.total};
      end
      f1_pos_in = sum[TOT_W-1:0];
      f1_bad_in = in_item.neg || (cfg.total == '0);
   end

   // first segment whose end lies past the position
   always_comb begin
      logic found;
      logic [IDX_W-1:0] idx;
      found = 1'b0;
      idx   = '0;
      for (int k = MAX_SEGMENTS - 1; k >= 0; k--) begin
         if (f1_pos_ff < seg_end[k]) begin
            found = 1'b1;
            idx   = seg_start[k][IDX_W-1:0] + f1_pos_ff[IDX_W-1:0]
                    - seg_begin[k][IDX_W-1:0];
         end
      end
      phys_valid_in = found && !f1_bad_ff;
      phys_index_in = phys_valid_in ? idx : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         f1_valid_ff <= in_valid;
         strobe_ff   <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      f1_bad_ff     <= f1_bad_in;
      f1_pos_ff     <= f1_pos_in;
      phys_valid_ff <= phys_valid_in;
      phys_index_ff <= phys_index_in;
   end

   assign out_strobe     = strobe_ff;
   assign out_phys_valid = phys_valid_ff;
   assign out_phys_index = phys_index_ff;

endmodule

>>> rtl/core/segmented_ring_index_map.sv
// ----------------------------------------------------------------------------
// segmented_ring_index_map
// Maps a logical ring position to a physical strip index over up to
// MAX_SEGMENTS clamped strip segments.
// ----------------------------------------------------------------------------
// usage
//   request: drive req_logical_pos and raise start; the word is taken at any
//   edge with start high and busy low. busy never rises, so a new word can
//   be taken at every clock edge.
//   response: rsp_strobe is high for one cycle with rsp_phys_valid and
//   rsp_phys_index; there is no hold-off, the receiver takes it then.
//   path: a word taken passes the input register, five remainder stages,
//   the fold stage and the output register on its way to the response.
//   throughput: one word per cycle, set by the pipelined restoring remainder
//   that resolves three quotient bits per stage.
//   settings: csr_we/csr_index/csr_wdata write one register per cycle; the user
//   must write only while no word is in flight, which the block does not check;
//   ring total and clamped segments follow in the next cycle, then boundaries.
//   reset: synchronous; clears the settings registers and valid flags and
//   flushes the pipeline, in-flight words are dropped.
//   negative positions and an empty ring give phys_valid 0 and index 0.
// ----------------------------------------------------------------------------
module segmented_ring_index_map #(
   parameter int MAX_LEDS     = srim_pkg::MAX_LEDS_DEF,
   parameter int MAX_SEGMENTS = srim_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [srim_pkg::POS_W-1:0]    req_logical_pos,
   // response channel
   output logic                                 rsp_strobe,
   output logic                                 rsp_phys_valid,
   output logic [srim_pkg::IDX_W-1:0]           rsp_phys_index,
   // register write port
   input  logic                                 csr_we,
   input  logic [srim_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [srim_pkg::CSR_DAT_W-1:0]       csr_wdata
);
   import srim_pkg::*;

   cfg_type                            cfg;
   logic [MAX_SEGMENTS-1:0][LEN_W-1:0] seg_start;
   logic [MAX_SEGMENTS-1:0][TOT_W-1:0] seg_begin;
   logic [MAX_SEGMENTS-1:0][TOT_W-1:0] seg_end;

   // input register
   logic             in_valid_ff;
   logic             in_neg_ff;
   logic [MAG_W-1:0] in_mag_ff;

   // remainder pipeline taps
   logic         div_valid [NUM_DIV_STAGES+1];
   div_item_type div_item  [NUM_DIV_STAGES+1];

   // the pipeline never stalls
   assign busy = 1'b0;

   srim_cfg #(
      .MAX_LEDS     (MAX_LEDS),
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .seg_start (seg_start),
      .seg_begin (seg_begin),
      .seg_end   (seg_end)
   );

   // capture the request word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      in_neg_ff <= req_logical_pos[POS_W-1];
      in_mag_ff <= req_logical_pos[MAG_W-1:0];
   end

   // both lanes enter the remainder chain together; the offset lane starts
   // from the current rotation magnitude
   assign div_valid[0]     = in_valid_ff;
   assign div_item[0].neg  = in_neg_ff;
   assign div_item[0].rem  = in_mag_ff;
   assign div_item[0].orem = MAG_W'(cfg.off_mag);

   for (genvar g = 0; g < NUM_DIV_STAGES; g++) begin : g_div
      srim_div_stage #(
         .FIRST_K (MAG_W - 1 - g * STEPS_PER_STAGE)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[g]),
         .in_item   (div_item[g]),
         .total     (cfg.total),
         .out_valid (div_valid[g+1]),
         .out_item  (div_item[g+1])
      );
   end

   // fold into the ring and find the segment
   srim_locate #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_locate (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (div_valid[NUM_DIV_STAGES]),
      .in_item        (div_item[NUM_DIV_STAGES]),
      .cfg            (cfg),
      .seg_start      (seg_start),
      .seg_begin      (seg_begin),
      .seg_end        (seg_end),
      .out_strobe     (rsp_strobe),
      .out_phys_valid (rsp_phys_valid),
      .out_phys_index (rsp_phys_index)
   );

   // every accepted word answers after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(NUM_DIV_STAGES + 3) rsp_strobe)
      else $error("response missing after fixed latency");

   // an invalid response carries a zero index
   a_zero_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_phys_valid) |-> (rsp_phys_index == '0))
      else $error("invalid response with nonzero index");

   // an empty ring never reports a hit
   a_empty_ring: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && cfg.total == '0) |-> !rsp_phys_valid)
      else $error("hit reported on an empty ring");

endmodule
